>>> sv/psn_pkg.sv
// Package: shared types, constants and helper functions for the protocol sniffer.
package psn_pkg;

  localparam int MaxLine = 1024;

  localparam logic [3:0] RP_CLOSED = 4'd15;
  localparam logic [3:0] RP_BAD    = 4'd14;

  typedef enum logic [2:0] {
    HP_NAME = 3'd0,
    HP_SKIP = 3'd1,
    HP_WS   = 3'd2,
    HP_SIGN = 3'd3,
    HP_DIG  = 3'd4,
    HP_STOP = 3'd5
  } hphase_t;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_HTTP    = 3'd1,
    KIND_WS      = 3'd2,
    KIND_MQTT    = 3'd3,
    KIND_TLS     = 3'd4
  } kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        secure;
    logic [7:0]  vmaj;
    logic [7:0]  vmin;
    logic [31:0] clen;
  } verdict_t;

  localparam logic [31:0] MagLimit = 32'h8000_0000;

  function automatic logic [7:0] lower8(input logic [7:0] c);
    lower8 = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] sat_dec8(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = {4'd0, acc} * 12'd10 + {8'd0, c[3:0]};
    sat_dec8 = (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  // keyword character k at position i, lowercase; zero past end
  function automatic logic [7:0] kw_char(input int k, input logic [4:0] i);
    logic [8*21-1:0] s;
    logic [4:0]      n;
    s = '0;
    n = 5'd0;
    case (k)
      0: begin s = {"upgrade", {14{8'h00}}}; n = 5'd7; end
      1: begin s = {"connection", {11{8'h00}}}; n = 5'd10; end
      2: begin s = {"sec-websocket-key", {4{8'h00}}}; n = 5'd17; end
      3: begin s = "sec-websocket-version"; n = 5'd21; end
      default: begin s = {"content-length", {7{8'h00}}}; n = 5'd14; end
    endcase
    if (i < n) kw_char = s[8*(20 - i) +: 8];
    else kw_char = 8'h00;
  endfunction

  function automatic logic [4:0] kw_len(input int k);
    case (k)
      0: kw_len = 5'd7;
      1: kw_len = 5'd10;
      2: kw_len = 5'd17;
      3: kw_len = 5'd21;
      default: kw_len = 5'd14;
    endcase
  endfunction

  function automatic logic [7:0] ws_char(input logic [4:0] i);
    logic [8*9-1:0] s;
    s = "websocket";
    ws_char = (i < 5'd9) ? s[8*(8 - i[3:0]) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] tag_char(input logic [3:0] p);
    logic [8*5-1:0] s;
    s = "HTTP/";
    tag_char = s[8*(4 - (p - 4'd5)) +: 8];
  endfunction

endpackage

>>> sv/protocol_sniffer_core.sv
// Top level: stream ports, input register, scanner and result register.
// Classifies one message that arrives one byte per request on the in_ channel,
// in_tlast on its final byte. For each final byte one verdict leaves on the
// out_ channel; other bytes produce nothing.
// Input bytes are registered, scanned by single-pass logic and the verdict is
// registered: a final byte passes the input register, then the result register.
// Throughput is one byte per cycle unless a final byte waits on a held verdict.
// The output register holds a verdict while out_tready is low; bytes keep
// flowing until the next final byte reaches the input register, then
// in_tready drops until the verdict is taken.
// cfg_ writes set the text window (reset 100); write only while idle.
// Synchronous active-low reset clears scan counters, flags and both valid bits.
module protocol_sniffer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [2:0] kind, [3] secure, [11:4] major,
                                  // [19:12] minor, [51:20] length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  win_r;
  logic        iv_r;
  logic [7:0]  ib_r;
  logic        il_r;
  logic        ov_r;
  psn_pkg::verdict_t vd, vd_r;
  logic        step, out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || out_tready;
  assign step      = iv_r && (out_free || !il_r);
  assign in_tready = !iv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= 8'd100;
    else if (cfg_valid) win_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ib_r <= in_tdata;
      il_r <= in_tlast;
    end
  end

  psn_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .c          (ib_r),
    .last       (il_r),
    .text_window(win_r),
    .verdict    (vd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step && il_r) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step && il_r) vd_r <= vd;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, vd_r.clen, vd_r.vmin, vd_r.vmaj, vd_r.secure, vd_r.kind};

endmodule

>>> sv/psn_scan.sv
// Per-byte message scanner: running state update and verdict for the final byte.
module psn_scan (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             c,
  input  logic                   last,
  input  logic [7:0]             text_window,
  output psn_pkg::verdict_t      verdict
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  head_r [8];
  logic        text_ok_r, text_ok_nxt;
  logic [3:0]  rphase_r, rphase_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic [7:0]  major_r, major_nxt, minor_r, minor_nxt;
  psn_pkg::hphase_t hphase_r, hphase_nxt;
  logic        prev_cr_r, prev_cr_nxt;
  logic [4:0]  name_len_r, name_len_nxt;
  logic [4:0]  kw_alive_r, kw_alive_nxt;
  logic        val_alive_r, val_alive_nxt;
  logic [4:0]  val_len_r, val_len_nxt;
  logic [31:0] len_acc_r, len_acc_nxt;
  logic        len_neg_r, len_neg_nxt;
  logic        ws_seen_r, ws_seen_nxt;
  logic [31:0] len_val_r, len_val_nxt;
  logic        hdone_r, hdone_nxt;
  logic [7:0]  h [8];

  // content character processing on a working copy of the line state
  function automatic void content_char(
    input  logic [7:0] ch,
    input  logic       done,
    inout  psn_pkg::hphase_t hp,
    inout  logic [4:0] nl,
    inout  logic [4:0] ka,
    inout  logic       va,
    inout  logic [4:0] vl,
    inout  logic [31:0] la,
    inout  logic       ln
  );
    logic [4:0]  pick;
    logic [35:0] prod;
    logic        go;
    pick = 5'd0;
    prod = '0;
    go = 1'b1;
    if (!done) begin
      if (hp == psn_pkg::HP_NAME) begin
        if (ch == 8'h3a) begin
          for (int k = 4; k >= 0; k--) begin
            if (ka[k]) pick = 5'd1 << k;
          end
          ka = pick;
          hp = psn_pkg::HP_SKIP;
        end else begin
          for (int k = 0; k < 5; k++) begin
            if (ka[k] && (nl >= psn_pkg::kw_len(k) ||
                psn_pkg::lower8(ch) != psn_pkg::kw_char(k, nl))) ka[k] = 1'b0;
          end
          if (nl < 5'd31) nl = nl + 5'd1;
        end
        go = 1'b0;
      end else if (hp == psn_pkg::HP_SKIP) begin
        if (ch == 8'h20) go = 1'b0;
        else hp = psn_pkg::HP_WS;
      end
      if (go) begin
        if (vl >= 5'd9 || psn_pkg::lower8(ch) != psn_pkg::ws_char(vl)) va = 1'b0;
        if (vl < 5'd31) begin
          vl = vl + 5'd1;
          case (hp)
            psn_pkg::HP_WS: begin
              if (!psn_pkg::is_ws(ch)) begin
                if (ch == 8'h2b) hp = psn_pkg::HP_SIGN;
                else if (ch == 8'h2d) begin ln = 1'b1; hp = psn_pkg::HP_SIGN; end
                else if (psn_pkg::is_digit(ch)) begin
                  la = {28'd0, ch[3:0]}; hp = psn_pkg::HP_DIG;
                end else hp = psn_pkg::HP_STOP;
              end
            end
            psn_pkg::HP_SIGN: begin
              if (psn_pkg::is_digit(ch)) begin
                la = {28'd0, ch[3:0]}; hp = psn_pkg::HP_DIG;
              end else hp = psn_pkg::HP_STOP;
            end
            psn_pkg::HP_DIG: begin
              if (!psn_pkg::is_digit(ch)) hp = psn_pkg::HP_STOP;
              else if (la > 32'd214748364) la = psn_pkg::MagLimit;
              else begin
                prod = {4'd0, la} * 36'd10 + {32'd0, ch[3:0]};
                la = (prod > {4'd0, psn_pkg::MagLimit}) ? psn_pkg::MagLimit : prod[31:0];
              end
            end
            default: ;
          endcase
        end
      end
    end
  endfunction

  always_comb begin
    logic [3:0] p;
    logic       pcr;
    logic       lend;
    logic       mqtt, tls;
    p = rphase_r;
    pcr = prev_cr_r;
    lend = 1'b0;
    for (int i = 0; i < 8; i++) h[i] = head_r[i];
    if (byte_count_r < 16'd8) h[byte_count_r[2:0]] = c;

    text_ok_nxt = text_ok_r;
    if ({8'd0, text_window} > byte_count_r &&
        (c < 8'd9 || (c > 8'd13 && c < 8'd32 && c != 8'd27))) text_ok_nxt = 1'b0;

    rphase_nxt = rphase_r;
    rvalid_nxt = rvalid_r;
    major_nxt  = major_r;
    minor_nxt  = minor_r;
    if (p != psn_pkg::RP_CLOSED) begin
      if (c == 8'd10 && pcr) begin
        rvalid_nxt = (p >= 4'd5) && (byte_count_r <= 16'(psn_pkg::MaxLine));
        rphase_nxt = psn_pkg::RP_CLOSED;
      end else if (byte_count_r >= 16'(psn_pkg::MaxLine)) begin
        rvalid_nxt = 1'b0;
        rphase_nxt = psn_pkg::RP_CLOSED;
      end else if (p <= 4'd3) begin
        if ((p[0] == 1'b0) != psn_pkg::is_ws(c)) rphase_nxt = p + 4'd1;
      end else if (!(p == 4'd4 && psn_pkg::is_ws(c))) begin
        if (p == 4'd4) p = 4'd5;
        if (psn_pkg::is_ws(c)) p = psn_pkg::RP_BAD;
        else if (p <= 4'd9) p = (c == psn_pkg::tag_char(p)) ? p + 4'd1 : psn_pkg::RP_BAD;
        else if (p == 4'd10) begin
          if (psn_pkg::is_digit(c)) begin major_nxt = {4'd0, c[3:0]}; p = 4'd11; end
          else p = psn_pkg::RP_BAD;
        end else if (p == 4'd11) begin
          if (psn_pkg::is_digit(c)) major_nxt = psn_pkg::sat_dec8(major_r, c);
          else p = (c == 8'h2e) ? 4'd12 : psn_pkg::RP_BAD;
        end else if (p == 4'd12) begin
          if (psn_pkg::is_digit(c)) begin minor_nxt = {4'd0, c[3:0]}; p = 4'd13; end
          else p = psn_pkg::RP_BAD;
        end else if (p == 4'd13) begin
          if (psn_pkg::is_digit(c)) minor_nxt = psn_pkg::sat_dec8(minor_r, c);
          else p = psn_pkg::RP_BAD;
        end
        rphase_nxt = p;
      end
    end

    hphase_nxt   = hphase_r;
    name_len_nxt = name_len_r;
    kw_alive_nxt = kw_alive_r;
    val_alive_nxt = val_alive_r;
    val_len_nxt  = val_len_r;
    len_acc_nxt  = len_acc_r;
    len_neg_nxt  = len_neg_r;
    ws_seen_nxt  = ws_seen_r;
    len_val_nxt  = len_val_r;
    hdone_nxt    = hdone_r;
    prev_cr_nxt  = prev_cr_r;
    if (pcr && c == 8'd10) begin
      lend = 1'b1;
      prev_cr_nxt = 1'b0;
    end else begin
      if (pcr) content_char(8'd13, hdone_r, hphase_nxt, name_len_nxt, kw_alive_nxt,
                            val_alive_nxt, val_len_nxt, len_acc_nxt, len_neg_nxt);
      if (c == 8'd13) prev_cr_nxt = 1'b1;
      else begin
        content_char(c, hdone_r, hphase_nxt, name_len_nxt, kw_alive_nxt,
                     val_alive_nxt, val_len_nxt, len_acc_nxt, len_neg_nxt);
        prev_cr_nxt = 1'b0;
      end
    end
    if (lend && !hdone_r) begin
      if (hphase_r == psn_pkg::HP_NAME) begin
        if (name_len_r == 5'd0) hdone_nxt = 1'b1;
      end else begin
        if (kw_alive_r[0] && val_alive_r) ws_seen_nxt = 1'b1;
        if (kw_alive_r[2] || kw_alive_r[3]) ws_seen_nxt = 1'b1;
        if (kw_alive_r[4]) begin
          if (len_neg_r) len_val_nxt = 32'd0 - len_acc_r;
          else len_val_nxt = len_acc_r[31] ? 32'h7fff_ffff : len_acc_r;
        end
      end
      hphase_nxt = psn_pkg::HP_NAME;
      name_len_nxt = 5'd0;
      kw_alive_nxt = 5'h1f;
      val_alive_nxt = 1'b1;
      val_len_nxt = 5'd0;
      len_acc_nxt = 32'd0;
      len_neg_nxt = 1'b0;
    end
    byte_count_nxt = (byte_count_r != 16'hffff) ? byte_count_r + 16'd1 : byte_count_r;

    mqtt = byte_count_nxt >= 16'd8 && h[0] == 8'h10 && h[2] == 8'h00 && h[3] == 8'h04 &&
           h[4] == 8'h4d && h[5] == 8'h51 && h[6] == 8'h54 && h[7] == 8'h54;
    tls  = byte_count_nxt >= 16'd6 && h[0] == 8'h16 && h[5] == 8'h01;
    verdict = '{kind: psn_pkg::KIND_UNKNOWN, secure: 1'b0, vmaj: 8'd0, vmin: 8'd0,
                clen: 32'hffff_ffff};
    if (mqtt) verdict.kind = psn_pkg::KIND_MQTT;
    else if (tls) begin
      verdict.kind = psn_pkg::KIND_TLS;
      verdict.secure = 1'b1;
    end else if (text_ok_nxt) begin
      verdict.kind = psn_pkg::KIND_HTTP;
      if (rvalid_nxt) begin
        if (ws_seen_nxt) verdict.kind = psn_pkg::KIND_WS;
        verdict.vmaj = major_nxt;
        verdict.vmin = minor_nxt;
        verdict.clen = len_val_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 8; i++) head_r[i] <= h[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      byte_count_r <= '0;
      text_ok_r <= 1'b1;
      rphase_r <= '0;
      rvalid_r <= 1'b0;
      major_r <= '0;
      minor_r <= '0;
      hphase_r <= psn_pkg::HP_NAME;
      prev_cr_r <= 1'b0;
      name_len_r <= '0;
      kw_alive_r <= 5'h1f;
      val_alive_r <= 1'b1;
      val_len_r <= '0;
      len_acc_r <= '0;
      len_neg_r <= 1'b0;
      ws_seen_r <= 1'b0;
      len_val_r <= 32'hffff_ffff;
      hdone_r <= 1'b0;
    end else if (step) begin
      byte_count_r <= byte_count_nxt;
      text_ok_r <= text_ok_nxt;
      rphase_r <= rphase_nxt;
      rvalid_r <= rvalid_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      hphase_r <= hphase_nxt;
      prev_cr_r <= prev_cr_nxt;
      name_len_r <= name_len_nxt;
      kw_alive_r <= kw_alive_nxt;
      val_alive_r <= val_alive_nxt;
      val_len_r <= val_len_nxt;
      len_acc_r <= len_acc_nxt;
      len_neg_r <= len_neg_nxt;
      ws_seen_r <= ws_seen_nxt;
      len_val_r <= len_val_nxt;
      hdone_r <= hdone_nxt;
    end
  end

endmodule

>>> sv/psn_check.sv
// Port checker for the protocol sniffer, bound to the top level.
module psn_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict dropped or changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= psn_pkg::KIND_TLS)
    else $error("kind out of range");

  a_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3] == (out_tdata[2:0] == psn_pkg::KIND_TLS))
    else $error("secure flag mismatch");

  a_nover: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != psn_pkg::KIND_HTTP) &&
      (out_tdata[2:0] != psn_pkg::KIND_WS)
      |-> out_tdata[51:20] == 32'hffff_ffff)
    else $error("length reported for non-http verdict");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> ##1 out_tvalid)
    else $error("verdict late");

endmodule

bind protocol_sniffer_core psn_check u_psn_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> verif/psn_checker.sv
// Checker: watches the sniffer channels, predicts each verdict and compares it.
`timescale 1ns / 1ps
module psn_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  string       kw_names[5] = '{"upgrade", "connection", "sec-websocket-key",
                               "sec-websocket-version", "content-length"};
  string       tag_text = "HTTP/";
  string       ws_text = "websocket";

  psn_pkg::verdict_t verdicts_due[$];
  logic [7:0]  window;
  int          byte_cnt;
  logic [7:0]  head[8];
  logic        text_ok, rq_valid, pcr, v_alive, lneg, ws_seen, hdone;
  logic [3:0]  rq_phase;
  logic [7:0]  maj, mnr;
  psn_pkg::hphase_t hd_phase;
  int          nlen, vlen;
  logic [4:0]  kw_alive;
  logic [31:0] lacc, lval;

  function automatic logic low8ok(input logic [7:0] c, input byte ref_c);
    logic [7:0] l;
    l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    return l == ref_c;
  endfunction

  function automatic logic white(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] dec_sat(input logic [7:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - 48;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  task automatic clear_line();
    hd_phase = psn_pkg::HP_NAME; nlen = 0; kw_alive = 5'h1f;
    v_alive = 1; vlen = 0; lacc = 0; lneg = 0;
  endtask

  task automatic clear_message();
    byte_cnt = 0;
    foreach (head[i]) head[i] = 0;
    text_ok = 1; rq_phase = 0; rq_valid = 0; maj = 0; mnr = 0;
    pcr = 0; ws_seen = 0; lval = 32'hffff_ffff; hdone = 0;
    clear_line();
  endtask

  task automatic track_request(input logic [7:0] c, input logic cr_before, input int idx);
    logic [3:0] p;
    p = rq_phase;
    if (p == psn_pkg::RP_CLOSED) return;
    if (c == 8'd10 && cr_before) begin
      rq_valid = (p >= 4'd5) && (idx <= psn_pkg::MaxLine);
      rq_phase = psn_pkg::RP_CLOSED;
      return;
    end
    if (idx >= psn_pkg::MaxLine) begin
      rq_valid = 0; rq_phase = psn_pkg::RP_CLOSED;
      return;
    end
    if (p <= 4'd3) begin
      if ((p[0] == 1'b0) != white(c)) rq_phase = p + 4'd1;
      return;
    end
    if (p == 4'd4) begin
      if (white(c)) return;
      p = 4'd5;
    end
    if (white(c)) begin
      rq_phase = psn_pkg::RP_BAD;
      return;
    end
    if (p <= 4'd9) p = (c == tag_text[p - 4'd5]) ? p + 4'd1 : psn_pkg::RP_BAD;
    else if (p == 4'd10) begin
      if (digit(c)) begin maj = c - 8'd48; p = 4'd11; end else p = psn_pkg::RP_BAD;
    end else if (p == 4'd11) begin
      if (digit(c)) maj = dec_sat(maj, c); else p = (c == ".") ? 4'd12 : psn_pkg::RP_BAD;
    end else if (p == 4'd12) begin
      if (digit(c)) begin mnr = c - 8'd48; p = 4'd13; end else p = psn_pkg::RP_BAD;
    end else if (p == 4'd13) begin
      if (digit(c)) mnr = dec_sat(mnr, c); else p = psn_pkg::RP_BAD;
    end
    rq_phase = p;
  endtask

  task automatic value_byte(input logic [7:0] c);
    if (vlen >= 9 || !low8ok(c, ws_text[vlen])) v_alive = 0;
    if (vlen >= 31) return;
    vlen++;
    case (hd_phase)
      psn_pkg::HP_WS: begin
        if (!white(c)) begin
          if (c == "+") hd_phase = psn_pkg::HP_SIGN;
          else if (c == "-") begin lneg = 1; hd_phase = psn_pkg::HP_SIGN; end
          else if (digit(c)) begin lacc = 32'(c) - 32'd48; hd_phase = psn_pkg::HP_DIG; end
          else hd_phase = psn_pkg::HP_STOP;
        end
      end
      psn_pkg::HP_SIGN: begin
        if (digit(c)) begin lacc = 32'(c) - 32'd48; hd_phase = psn_pkg::HP_DIG; end
        else hd_phase = psn_pkg::HP_STOP;
      end
      psn_pkg::HP_DIG: begin
        if (!digit(c)) hd_phase = psn_pkg::HP_STOP;
        else if (lacc > 32'd214748364) lacc = psn_pkg::MagLimit;
        else begin
          lacc = lacc * 32'd10 + 32'(c) - 32'd48;
          if (lacc > psn_pkg::MagLimit) lacc = psn_pkg::MagLimit;
        end
      end
      default: ;
    endcase
  endtask

  task automatic line_byte(input logic [7:0] c);
    logic [4:0] pick;
    if (hdone) return;
    if (hd_phase == psn_pkg::HP_NAME) begin
      if (c == ":") begin
        pick = 0;
        for (int k = 4; k >= 0; k--) if (kw_alive[k]) pick = 5'd1 << k;
        kw_alive = pick;
        hd_phase = psn_pkg::HP_SKIP;
        return;
      end
      for (int k = 0; k < 5; k++)
        if (kw_alive[k] && (nlen >= kw_names[k].len() || !low8ok(c, kw_names[k][nlen])))
          kw_alive[k] = 0;
      if (nlen < 31) nlen++;
      return;
    end
    if (hd_phase == psn_pkg::HP_SKIP) begin
      if (c == " ") return;
      hd_phase = psn_pkg::HP_WS;
    end
    value_byte(c);
  endtask

  task automatic close_line();
    if (hdone) return;
    if (hd_phase == psn_pkg::HP_NAME) begin
      if (nlen == 0) hdone = 1;
    end else begin
      if (kw_alive[0] && v_alive) ws_seen = 1;
      if (kw_alive[2] || kw_alive[3]) ws_seen = 1;
      if (kw_alive[4]) begin
        if (lneg) lval = -lacc;
        else lval = (lacc > 32'h7fff_ffff) ? 32'h7fff_ffff : lacc;
      end
    end
    clear_line();
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic last);
    psn_pkg::verdict_t v;
    logic cr_was;
    cr_was = pcr;
    if (byte_cnt < 8) head[byte_cnt] = c;
    if (byte_cnt < window && (c < 8'd9 || (c > 8'd13 && c < 8'd32 && c != 8'd27)))
      text_ok = 0;
    track_request(c, cr_was, byte_cnt);
    if (cr_was && c == 8'd10) begin
      close_line(); pcr = 0;
    end else begin
      if (cr_was) line_byte(8'd13);
      if (c == 8'd13) pcr = 1;
      else begin
        line_byte(c); pcr = 0;
      end
    end
    if (byte_cnt < 65535) byte_cnt++;
    if (!last) return;
    v = '0;
    v.kind = psn_pkg::KIND_UNKNOWN;
    v.clen = 32'hffff_ffff;
    if (byte_cnt >= 8 && head[0] == 8'h10 && head[2] == 0 && head[3] == 8'h04 &&
        head[4] == "M" && head[5] == "Q" && head[6] == "T" && head[7] == "T") begin
      v.kind = psn_pkg::KIND_MQTT;
    end else if (byte_cnt >= 6 && head[0] == 8'h16 && head[5] == 8'h01) begin
      v.kind = psn_pkg::KIND_TLS; v.secure = 1;
    end else if (text_ok) begin
      v.kind = psn_pkg::KIND_HTTP;
      if (rq_valid) begin
        if (ws_seen) v.kind = psn_pkg::KIND_WS;
        v.vmaj = maj; v.vmin = mnr; v.clen = lval;
      end
    end
    verdicts_due.push_back(v);
    clear_message();
  endtask

  always @(posedge clk) begin
    psn_pkg::verdict_t got, want;
    if (!rst_n) begin
      window = 8'd100;
      clear_message();
      verdicts_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) window = cfg_data;
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got = psn_pkg::verdict_t'({out_tdata[2:0], out_tdata[3], out_tdata[11:4],
                                   out_tdata[19:12], out_tdata[51:20]});
        if (verdicts_due.size() == 0) begin
          $error("unexpected verdict %h", out_tdata);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("protocol_kind: expected %0d actual %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.secure !== want.secure) begin
            $error("secure: expected %0d actual %0d", want.secure, got.secure);
            fail_count++;
          end
          if (got.vmaj !== want.vmaj) begin
            $error("vmaj: expected %0d actual %0d", want.vmaj, got.vmaj);
            fail_count++;
          end
          if (got.vmin !== want.vmin) begin
            $error("vmin: expected %0d actual %0d", want.vmin, got.vmin);
            fail_count++;
          end
          if (got.clen !== want.clen) begin
            $error("clen: expected %0d actual %0d",
                   $signed(want.clen), $signed(got.clen));
            fail_count++;
          end
        end
      end
    end
    pending = verdicts_due.size();
  end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives messages and register writes into the sniffer, gives the verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int IdleLimit = 20000;
  localparam int HoldLen = 300;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tlast;
  logic [7:0]  in_tdata;
  logic        out_tvalid, out_tready;
  logic [55:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_took, cfg_took;
  int          fail_count, pending;
  int          send_idle, recv_stall, quiet, bytes_sent, msgs_sent;
  bit          long_hold;
  int          hold_cnt;
  byte         msg[$];

  protocol_sniffer_core i_dut (.*);

  psn_checker i_check (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    in_took  <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // receiver: random stalls, or one long counted hold-off on request
  always @(negedge clk) begin
    if (long_hold && hold_cnt < HoldLen) begin
      out_tready <= 0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add(input string s);
    foreach (s[i]) msg.push_back(s[i]);
  endtask

  function automatic string mix_case(input string s);
    string r;
    r = s;
    foreach (r[i])
      if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = byte'(r[i] - 8'd32);
    return r;
  endfunction

  function automatic string some_text(input int n);
    string r;
    r = "";
    for (int i = 0; i < n; i++) r = {r, $sformatf("%c", 8'($urandom_range(33, 126)))};
    return r;
  endfunction

  function automatic string number_text();
    case ($urandom_range(5))
      0: return "0";
      1: return $sformatf("%0d", $urandom_range(9));
      2: return $sformatf("%0d", $urandom_range(999));
      3: return $sformatf("%0d", $urandom);
      4: return "99999999999999";
      default: return $sformatf("%0d", $urandom_range(300));
    endcase
  endfunction

  task automatic add_header();
    string names[8] = '{"Upgrade", "Connection", "Sec-WebSocket-Key",
                        "Sec-WebSocket-Version", "Content-Length", "Host", "", "X-Id"};
    string ws_word;
    string n, v, gap;
    ws_word = "websocket";
    n = names[$urandom_range(7)];
    if ($urandom_range(4) == 0 && n.len() > 0) n = n.substr(0, $urandom_range(n.len() - 1));
    n = mix_case(n);
    case ($urandom_range(5))
      0: v = mix_case(ws_word.substr(0, $urandom_range(8)));
      1: v = number_text();
      2: v = {"-", number_text()};
      3: v = {"+", number_text()};
      4: v = "";
      default: v = some_text($urandom_range(1, 40));
    endcase
    gap = ":";
    if ($urandom_range(1)) gap = {gap, " "};
    if ($urandom_range(3) == 0) gap = {gap, "  "};
    add({n, gap, v, "\r\n"});
  endtask

  task automatic build_http(input bit tidy);
    string methods[4] = '{"GET", "POST", "PUT", "OPTIONS"};
    string sep;
    sep = " ";
    if ($urandom_range(5) == 0) sep = "\t ";
    add({methods[$urandom_range(3)], sep, "/", some_text($urandom_range(0, 12)), " "});
    case (tidy ? 0 : $urandom_range(4))
      0: add({"HTTP/", number_text(), ".", number_text()});
      1: add({"HTTP/", number_text()});
      2: add({"HTTP/-", number_text(), ".+1"});
      3: add({"HTTP/1.1 extra"});
      default: add({"HTP/1.", number_text()});
    endcase
    add("\r\n");
    repeat ($urandom_range(0, 5)) add_header();
    if ($urandom_range(4) != 0) add("\r\n");
    if ($urandom_range(2) == 0) add(some_text($urandom_range(1, 10)));
  endtask

  task automatic build_random();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: build_http($urandom_range(2) != 0);
      5: begin
        msg = '{8'h10, byte'($urandom), 8'h00, 8'h04, "M", "Q", "T", "T"};
        if ($urandom_range(2) == 0) msg[$urandom_range(7)] = byte'($urandom);
        repeat ($urandom_range(0, 6)) msg.push_back(byte'($urandom));
      end
      6: begin
        msg = '{8'h16, 8'h03, 8'h01, byte'($urandom), byte'($urandom), 8'h01};
        if ($urandom_range(2) == 0) msg[$urandom_range(5)] = byte'($urandom);
        repeat ($urandom_range(0, 6)) msg.push_back(byte'($urandom));
      end
      7: repeat ($urandom_range(1, 20)) msg.push_back(byte'($urandom));
      8: begin
        add({"GET / HTTP/1.0\r", some_text(3), "\r\r\n"});
        repeat ($urandom_range(1, 4)) msg.push_back(byte'($urandom_range(0, 31)));
      end
      default: add(some_text($urandom_range(1, 30)));
    endcase
  endtask

  task automatic push_byte(input byte b, input bit last);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic send_msg();
    foreach (msg[i]) push_byte(msg[i], i == msg.size() - 1);
    bytes_sent += msg.size();
    msgs_sent++;
    msg.delete();
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [7:0] w);
    drain();
    cfg_valid <= 1;
    cfg_data  <= w;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 0;
  endtask

  initial begin
    logic [7:0] windows[4];
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tlast = 0;
    cfg_valid = 0; cfg_data = 0;
    send_idle = 0; recv_stall = 0; long_hold = 0;
    bytes_sent = 0; msgs_sent = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed cases
    add("GET /index HTTP/1.1\r\nUpgrade: websocket\r\nContent-Length: 42\r\n\r\n"); send_msg();
    add("GET / HTTP/300.999\r\nsec-websocket-key: x\r\ncontent-length:-7\r\n\r\n"); send_msg();
    add("PUT /a HTTP/1.0\r\nContent-Length: 99999999999\r\nCONTENT-LENGTH: -99999999999\r\n");
    send_msg();
    add("GET / HTTP/+1.-1\r\n:\r\n"); send_msg();
    add("POST x HTTP/2\r\nupg: webs\r\nConnection: websocket\r\n\r\nUpgrade: websocket\r\n");
    send_msg();
    add("GET /no-line-end HTTP/1.1"); send_msg();
    add("GET\r / HTTP/1.1\rX\r\n"); send_msg();
    add("a b\r\n"); send_msg();
    msg = '{8'h10, 8'h00, 8'h00, 8'h04, "M", "Q", "T", "T"}; send_msg();
    msg = '{8'h10, 8'h00, 8'h00, 8'h04, "M", "Q", "T"}; send_msg();
    msg = '{8'h16, 8'h03, 8'h01, 8'h00, 8'hff, 8'h01}; send_msg();
    msg = '{8'h16, 8'h03, 8'h01, 8'h00, 8'hff}; send_msg();
    msg = '{8'h00}; send_msg();
    msg = '{8'hff}; send_msg();
    msg = '{8'h1b, 8'h09, 8'h0d, 8'h20, 8'h7f, 8'h80}; send_msg();
    add("GET / HTTP/1.1\r\nHost: a"); msg.push_back(8'h00); add("b\r\n\r\n"); send_msg();

    windows = '{8'd1, 8'd255, 8'd7, 8'd100};
    for (int ph = 0; ph < 4; ph++) begin
      write_window(ph == 2 ? 8'($urandom_range(1, 255)) : windows[ph]);
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      bytes_sent = 0; msgs_sent = 0;
      while (bytes_sent < 200) begin
        if (ph == 0 && msgs_sent == 0) long_hold = 1;
        build_random();
        send_msg();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
